FILE: rtl/qsta_pkg.sv
// ----------------------------------------------------------------------------
// qsta_pkg
// Types and constants shared by the quaternion/scale/translation to affine
// matrix pipeline.
// ----------------------------------------------------------------------------
package qsta_pkg;

  // Bits dropped when going from Q12.36 down to Q16.16
  localparam int unsigned FracDrop = 20;
  // Rotation entry width: exact Q4.28 value of 1 - 2(a+b) or 2(a-b)
  localparam int unsigned RotW     = 34;
  // Scaled entry width: Q4.28 times Q8.8, exact
  localparam int unsigned PrdW     = RotW + 16;
  // Rounding sum and shifted value widths
  localparam int unsigned SumW     = PrdW + 3;
  localparam int unsigned QntW     = SumW - FracDrop;

  typedef logic signed [15:0]     q16_t;
  typedef logic signed [31:0]     q32_t;
  typedef logic signed [RotW-1:0] rot_ent_t;
  typedef logic signed [PrdW-1:0] prd_ent_t;
  typedef logic signed [SumW-1:0] sum_t;
  typedef logic signed [QntW-1:0] qnt_t;

  localparam rot_ent_t OneQ28  = rot_ent_t'(64'sd268435456);
  localparam sum_t     RndHalf = sum_t'(64'sd524288);
  localparam qnt_t     SatMax  = qnt_t'(64'sd2147483647);
  localparam qnt_t     SatMin  = qnt_t'(-64'sd2147483648);

  typedef struct packed {
    q16_t quat_x;
    q16_t quat_y;
    q16_t quat_z;
    q16_t quat_w;
    q16_t scale_x;
    q16_t scale_y;
    q16_t scale_z;
    q32_t trans_x;
    q32_t trans_y;
    q32_t trans_z;
  } in_t;

  typedef struct packed {
    q32_t m00;
    q32_t m01;
    q32_t m02;
    q32_t m10;
    q32_t m11;
    q32_t m12;
    q32_t m20;
    q32_t m21;
    q32_t m22;
    q32_t m30;
    q32_t m31;
    q32_t m32;
  } out_t;

  // Quaternion products, Q4.28
  typedef struct packed {
    q32_t xx;
    q32_t yy;
    q32_t zz;
    q32_t xy;
    q32_t xz;
    q32_t yz;
    q32_t wx;
    q32_t wy;
    q32_t wz;
    q16_t sx;
    q16_t sy;
    q16_t sz;
    q32_t tx;
    q32_t ty;
    q32_t tz;
  } prod_t;

  // Rotation matrix entries, Q4.28
  typedef struct packed {
    rot_ent_t r00;
    rot_ent_t r01;
    rot_ent_t r02;
    rot_ent_t r10;
    rot_ent_t r11;
    rot_ent_t r12;
    rot_ent_t r20;
    rot_ent_t r21;
    rot_ent_t r22;
    q16_t     sx;
    q16_t     sy;
    q16_t     sz;
    q32_t     tx;
    q32_t     ty;
    q32_t     tz;
  } rot_t;

  // Scaled rotation entries, Q12.36
  typedef struct packed {
    prd_ent_t p00;
    prd_ent_t p01;
    prd_ent_t p02;
    prd_ent_t p10;
    prd_ent_t p11;
    prd_ent_t p12;
    prd_ent_t p20;
    prd_ent_t p21;
    prd_ent_t p22;
    q32_t     tx;
    q32_t     ty;
    q32_t     tz;
  } scl_t;

  // Round half up from Q12.36 to Q16.16, then clamp to the 32-bit range
  function automatic q32_t round_sat(prd_ent_t p);
    sum_t t;
    qnt_t q;
    t = sum_t'(p) + RndHalf;
    q = t[SumW-1:FracDrop];
    if (q > SatMax) begin
      return q32_t'(SatMax);
    end else if (q < SatMin) begin
      return q32_t'(SatMin);
    end else begin
      return q[31:0];
    end
  endfunction

endpackage

FILE: rtl/qsta_prod.sv
// ----------------------------------------------------------------------------
// qsta_prod
// First stage: the nine quaternion component products, registered.
// ----------------------------------------------------------------------------
module qsta_prod import qsta_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  in_t   data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output prod_t data_o
);

  logic  valid_q;
  prod_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.xx = q32_t'(data_i.quat_x) * q32_t'(data_i.quat_x);
    data_d.yy = q32_t'(data_i.quat_y) * q32_t'(data_i.quat_y);
    data_d.zz = q32_t'(data_i.quat_z) * q32_t'(data_i.quat_z);
    data_d.xy = q32_t'(data_i.quat_x) * q32_t'(data_i.quat_y);
    data_d.xz = q32_t'(data_i.quat_x) * q32_t'(data_i.quat_z);
    data_d.yz = q32_t'(data_i.quat_y) * q32_t'(data_i.quat_z);
    data_d.wx = q32_t'(data_i.quat_w) * q32_t'(data_i.quat_x);
    data_d.wy = q32_t'(data_i.quat_w) * q32_t'(data_i.quat_y);
    data_d.wz = q32_t'(data_i.quat_w) * q32_t'(data_i.quat_z);
    data_d.sx = data_i.scale_x;
    data_d.sy = data_i.scale_y;
    data_d.sz = data_i.scale_z;
    data_d.tx = data_i.trans_x;
    data_d.ty = data_i.trans_y;
    data_d.tz = data_i.trans_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/qsta_rot.sv
// ----------------------------------------------------------------------------
// qsta_rot
// Second stage: combine the products into the nine rotation entries.
// ----------------------------------------------------------------------------
module qsta_rot import qsta_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  prod_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output rot_t  data_o
);

  logic valid_q;
  rot_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.r00 = OneQ28 - ((rot_ent_t'(data_i.yy) + rot_ent_t'(data_i.zz)) <<< 1);
    data_d.r01 = (rot_ent_t'(data_i.xy) - rot_ent_t'(data_i.wz)) <<< 1;
    data_d.r02 = (rot_ent_t'(data_i.xz) + rot_ent_t'(data_i.wy)) <<< 1;
    data_d.r10 = (rot_ent_t'(data_i.xy) + rot_ent_t'(data_i.wz)) <<< 1;
    data_d.r11 = OneQ28 - ((rot_ent_t'(data_i.xx) + rot_ent_t'(data_i.zz)) <<< 1);
    data_d.r12 = (rot_ent_t'(data_i.yz) - rot_ent_t'(data_i.wx)) <<< 1;
    data_d.r20 = (rot_ent_t'(data_i.xz) - rot_ent_t'(data_i.wy)) <<< 1;
    data_d.r21 = (rot_ent_t'(data_i.yz) + rot_ent_t'(data_i.wx)) <<< 1;
    data_d.r22 = OneQ28 - ((rot_ent_t'(data_i.xx) + rot_ent_t'(data_i.yy)) <<< 1);
    data_d.sx  = data_i.sx;
    data_d.sy  = data_i.sy;
    data_d.sz  = data_i.sz;
    data_d.tx  = data_i.tx;
    data_d.ty  = data_i.ty;
    data_d.tz  = data_i.tz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/qsta_mul.sv
// ----------------------------------------------------------------------------
// qsta_mul
// Third stage: multiply each rotation row by its axis scale.
// ----------------------------------------------------------------------------
module qsta_mul import qsta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  rot_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output scl_t data_o
);

  logic valid_q;
  scl_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.p00 = prd_ent_t'(data_i.r00) * prd_ent_t'(data_i.sx);
    data_d.p01 = prd_ent_t'(data_i.r01) * prd_ent_t'(data_i.sx);
    data_d.p02 = prd_ent_t'(data_i.r02) * prd_ent_t'(data_i.sx);
    data_d.p10 = prd_ent_t'(data_i.r10) * prd_ent_t'(data_i.sy);
    data_d.p11 = prd_ent_t'(data_i.r11) * prd_ent_t'(data_i.sy);
    data_d.p12 = prd_ent_t'(data_i.r12) * prd_ent_t'(data_i.sy);
    data_d.p20 = prd_ent_t'(data_i.r20) * prd_ent_t'(data_i.sz);
    data_d.p21 = prd_ent_t'(data_i.r21) * prd_ent_t'(data_i.sz);
    data_d.p22 = prd_ent_t'(data_i.r22) * prd_ent_t'(data_i.sz);
    data_d.tx  = data_i.tx;
    data_d.ty  = data_i.ty;
    data_d.tz  = data_i.tz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/qsta_rnd.sv
// ----------------------------------------------------------------------------
// qsta_rnd
// Last stage: round to Q16.16, clamp, and hold the result for the output.
// ----------------------------------------------------------------------------
module qsta_rnd import qsta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  scl_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output out_t data_o
);

  logic valid_q;
  out_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.m00 = round_sat(data_i.p00);
    data_d.m01 = round_sat(data_i.p01);
    data_d.m02 = round_sat(data_i.p02);
    data_d.m10 = round_sat(data_i.p10);
    data_d.m11 = round_sat(data_i.p11);
    data_d.m12 = round_sat(data_i.p12);
    data_d.m20 = round_sat(data_i.p20);
    data_d.m21 = round_sat(data_i.p21);
    data_d.m22 = round_sat(data_i.p22);
    data_d.m30 = data_i.tx;
    data_d.m31 = data_i.ty;
    data_d.m32 = data_i.tz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/quat_scale_trans_to_affine_unit.sv
// Builds the 4x3 affine matrix (row-vector form, last column 0,0,0,1 implied)
// from a Q2.14 quaternion, a Q8.8 per-row scale and a Q16.16 translation.
// The quaternion is used as given, without normalization; scaled entries are
// rounded half up to Q16.16 and clamped. One transfer is taken every clock
// while the output is ready. Each result passes in order through the four
// register stages: component products, rotation sums, scale multiply, and
// the round/clamp output register. Each stage holds its own valid bit and
// takes a new item whenever it is empty or its successor moves, so bubbles
// close up while the output waits.
// ----------------------------------------------------------------------------
// quat_scale_trans_to_affine_unit
// Top level of the quaternion/scale/translation to affine matrix pipeline.
// ----------------------------------------------------------------------------
module quat_scale_trans_to_affine_unit import qsta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic  prod_valid, prod_ready;
  prod_t prod_data;
  logic  rot_valid, rot_ready;
  rot_t  rot_data;
  logic  mul_valid, mul_ready;
  scl_t  mul_data;

  qsta_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  qsta_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .valid_o (rot_valid),
    .ready_i (rot_ready),
    .data_o  (rot_data)
  );

  qsta_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .data_i  (rot_data),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .data_o  (mul_data)
  );

  qsta_rnd u_rnd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .data_i  (mul_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // An empty output register lets every stage advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is taken");

  // With the output kept ready, an accepted item reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, 4) && $past(in_valid_i && in_ready_o, 4) &&
     $past(out_ready_i, 1) && $past(out_ready_i, 2) && $past(out_ready_i, 3))
    |-> out_valid_o)
    else $error("accepted transfer did not reach output in four cycles");

  // The product stage only fills with data that came in through the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(prod_valid) |-> $past(in_valid_i && in_ready_o))
    else $error("product stage filled without an input transfer");

endmodule
